### rtl/core/cpuaff_pkg.sv
// Package for the CPU affinity mask generator.
// Holds shared widths, codes, state and status types used by all core modules.
// No dependencies.
package cpuaff_pkg;

    localparam int MAX_CPUS_DEF = 64;
    localparam int CNT_W        = 7;
    localparam int ID_W         = 6;
    localparam int DIVD_W       = 12;
    localparam int CFG_IDX_W    = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_AVAIL_MASK = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ONLINE     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TASKS      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_REQ_CPT    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_START      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_REVERSE    = 3'd5;

    localparam logic REQ_LOAD = 1'b0;

    typedef enum logic [1:0] {
        ST_LOADED = 2'd0,
        ST_MASK   = 2'd1,
        ST_SKIP   = 2'd2,
        ST_ERROR  = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN,
        S_CHECK,
        S_DIV_CPT,
        S_MUL,
        S_POS_GO,
        S_DIV_POS,
        S_MAP_RD,
        S_RANK,
        S_ACC,
        S_DONE
    } t_state;

    typedef struct packed {
        logic             done;
        logic [CNT_W-1:0] avail_cnt;
        logic [CNT_W-1:0] lim_cnt;
    } t_rank_stat;

    typedef struct packed {
        logic              done;
        logic [DIVD_W-1:0] quotient;
        logic [CNT_W-1:0]  remainder;
    } t_div_res;

endpackage

### rtl/core/cpuaff_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on cpuaff_pkg for widths and the result struct.
module cpuaff_div
    import cpuaff_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [DIVD_W-1:0] i_dividend,
    input  logic [CNT_W-1:0]  i_divisor,
    output t_div_res          o_res
);

    localparam int STEP_W = $clog2(DIVD_W);

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_step;
    logic [DIVD_W-1:0] r_quo;
    logic [CNT_W-1:0]  r_rem;
    logic [CNT_W-1:0]  r_div;
    logic [CNT_W:0]    trial;
    logic              fits;

    assign trial = {r_rem, r_quo[DIVD_W-1]};
    assign fits  = trial >= {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + 1'b1;
                if (r_step == STEP_W'(DIVD_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            if (fits) begin
                r_rem <= CNT_W'(trial - {1'b0, r_div});
            end else begin
                r_rem <= trial[CNT_W-1:0];
            end
            r_quo <= {r_quo[DIVD_W-2:0], fits};
        end
    end

    assign o_res.done      = r_done;
    assign o_res.quotient  = r_quo;
    assign o_res.remainder = r_rem;

endmodule

### rtl/core/cpuaff_map.sv
// Position map memory: physical position to logical CPU id.
// Depends on cpuaff_pkg for the id width.
module cpuaff_map
    import cpuaff_pkg::*;
#(
    parameter int MAX_CPUS = MAX_CPUS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_we,
    input  logic [$clog2(MAX_CPUS)-1:0] i_waddr,
    input  logic [ID_W-1:0]             i_wdata,
    input  logic [$clog2(MAX_CPUS)-1:0] i_raddr,
    output logic [ID_W-1:0]             o_rdata
);

    logic [ID_W-1:0] r_mem [MAX_CPUS];
    logic [ID_W-1:0] r_rdata;

    // Writes happen only when the block is idle, so reads never collide.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/core/cpuaff_rank.sv
// Rank table builder: scans the available mask and stores the CPU number of each
// usable CPU by rank. Depends on cpuaff_pkg for counts and the status struct.
module cpuaff_rank
    import cpuaff_pkg::*;
#(
    parameter int MAX_CPUS = MAX_CPUS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [MAX_CPUS-1:0]         i_avail,
    input  logic [CNT_W-1:0]            i_online,
    input  logic [$clog2(MAX_CPUS)-1:0] i_raddr,
    output logic [$clog2(MAX_CPUS)-1:0] o_rdata,
    output t_rank_stat                  o_stat
);

    localparam int IW = $clog2(MAX_CPUS);

    logic [IW-1:0]    r_mem [MAX_CPUS];
    logic [IW-1:0]    r_rdata;
    logic             r_busy;
    logic             r_done;
    logic [IW-1:0]    r_idx;
    logic [CNT_W-1:0] r_avail_cnt;
    logic [CNT_W-1:0] r_lim_cnt;
    logic             in_limit;

    assign in_limit = CNT_W'(r_idx) < i_online;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_done      <= 1'b0;
            r_idx       <= '0;
            r_avail_cnt <= '0;
            r_lim_cnt   <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy      <= 1'b1;
                r_idx       <= '0;
                r_avail_cnt <= '0;
                r_lim_cnt   <= '0;
            end else if (r_busy) begin
                if (i_avail[r_idx]) begin
                    r_avail_cnt <= r_avail_cnt + 1'b1;
                    if (in_limit) begin
                        r_lim_cnt <= r_lim_cnt + 1'b1;
                    end
                end
                if (r_idx == IW'(MAX_CPUS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_idx <= r_idx + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_busy && i_avail[r_idx] && in_limit) begin
            r_mem[r_lim_cnt[IW-1:0]] <= r_idx;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata          = r_rdata;
    assign o_stat.done      = r_done;
    assign o_stat.avail_cnt = r_avail_cnt;
    assign o_stat.lim_cnt   = r_lim_cnt;

endmodule

### rtl/core/cpu_affinity_mask_gen.sv
// Top level of the CPU affinity mask generator.
// Depends on cpuaff_pkg, cpuaff_div, cpuaff_map and cpuaff_rank.
//
// A load transaction writes one position map entry. Its result passes through the
// done state into the output register. A generate transaction first scans the
// available mask into a rank table. Unless the task is skipped, it then divides
// once or twice in a shared 12-step divider, and walks the position map, reading
// the map entry and then the rank table entry for each CPU. With a derived CPU
// count the CPUs per task are first divided out of the available count; with an
// explicit count only the position is divided. A skipped task goes from the scan
// check straight to the result, and a map error ends the walk early. The next
// input can be accepted in the same cycle that the result becomes valid. One
// transaction is in work at a time; the finished result sits in an output register
// so a new input can be accepted while it waits.
module cpu_affinity_mask_gen
    import cpuaff_pkg::*;
#(
    parameter int MAX_CPUS = MAX_CPUS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [63:0]          i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic                 i_req_type,
    input  logic [ID_W-1:0]      i_map_index,
    input  logic [ID_W-1:0]      i_map_cpu_id,
    input  logic [ID_W-1:0]      i_task_id,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [63:0]          o_cpu_mask,
    output logic [1:0]           o_status
);

    localparam int IW = $clog2(MAX_CPUS);

    logic [MAX_CPUS-1:0] r_avail;
    logic [CNT_W-1:0]    r_online;
    logic [CNT_W-1:0]    r_tasks;
    logic [CNT_W-1:0]    r_req_cpt;
    logic [ID_W-1:0]     r_start;
    logic                r_reverse;

    t_state              r_state, n_state;
    logic [ID_W-1:0]     r_task_id, n_task_id;
    logic [CNT_W-1:0]    r_cpt, n_cpt;
    logic [CNT_W-1:0]    r_pos, n_pos;
    logic [CNT_W-1:0]    r_k, n_k;
    logic [DIVD_W-1:0]   r_prod, n_prod;
    logic [MAX_CPUS-1:0] r_mask, n_mask;
    t_status             r_res_status, n_res_status;
    logic                r_out_valid, n_out_valid;
    logic [MAX_CPUS-1:0] r_out_mask, n_out_mask;
    t_status             r_out_status, n_out_status;

    logic                in_accept;
    logic                map_we;
    logic [IW-1:0]       map_raddr;
    logic [ID_W-1:0]     map_rdata;
    logic                rank_start;
    logic [IW-1:0]       rank_raddr;
    logic [IW-1:0]       rank_rdata;
    t_rank_stat          rank_stat;
    logic                div_start;
    logic [DIVD_W-1:0]   div_dividend;
    logic [CNT_W-1:0]    div_divisor;
    t_div_res            div_res;

    logic [CNT_W-1:0]    avail_cnt;
    logic [CNT_W-1:0]    tasks_eff;
    logic                skip;
    logic                cpt_derive;
    logic                id_bad;
    logic [CNT_W-1:0]    pos_next;
    logic [CNT_W-1:0]    rem_pos;

    assign in_accept = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != S_IDLE);
    assign map_we = in_accept && (i_req_type == REQ_LOAD) &&
                    ({1'b0, i_map_index} < CNT_W'(MAX_CPUS));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_avail   <= '1;
            r_online  <= CNT_W'(64);
            r_tasks   <= CNT_W'(1);
            r_req_cpt <= '0;
            r_start   <= '0;
            r_reverse <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_AVAIL_MASK: r_avail   <= i_cfg_data[MAX_CPUS-1:0];
                CFG_ONLINE:     r_online  <= i_cfg_data[CNT_W-1:0];
                CFG_TASKS:      r_tasks   <= i_cfg_data[CNT_W-1:0];
                CFG_REQ_CPT:    r_req_cpt <= i_cfg_data[CNT_W-1:0];
                CFG_START:      r_start   <= i_cfg_data[ID_W-1:0];
                CFG_REVERSE:    r_reverse <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    cpuaff_map #(
        .MAX_CPUS(MAX_CPUS)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (map_we),
        .i_waddr (i_map_index[IW-1:0]),
        .i_wdata (i_map_cpu_id),
        .i_raddr (map_raddr),
        .o_rdata (map_rdata)
    );

    cpuaff_rank #(
        .MAX_CPUS(MAX_CPUS)
    ) u_rank (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (rank_start),
        .i_avail  (r_avail),
        .i_online (r_online),
        .i_raddr  (rank_raddr),
        .o_rdata  (rank_rdata),
        .o_stat   (rank_stat)
    );

    cpuaff_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_res      (div_res)
    );

    assign avail_cnt  = rank_stat.avail_cnt;
    assign tasks_eff  = (r_tasks == '0) ? CNT_W'(1) : r_tasks;
    assign skip       = (avail_cnt <= CNT_W'(1)) ||
                        ((tasks_eff <= CNT_W'(1)) && (r_req_cpt == '0)) ||
                        (tasks_eff > avail_cnt);
    assign cpt_derive = (r_req_cpt == '0) || (r_req_cpt > avail_cnt);
    assign id_bad     = ({1'b0, map_rdata} >= avail_cnt) ||
                        ({1'b0, map_rdata} >= rank_stat.lim_cnt);
    assign rem_pos    = r_reverse ? (avail_cnt - CNT_W'(1) - div_res.remainder)
                                  : div_res.remainder;

    always_comb begin
        if (r_reverse) begin
            pos_next = (r_pos == '0) ? (avail_cnt - CNT_W'(1)) : (r_pos - CNT_W'(1));
        end else begin
            pos_next = (r_pos + CNT_W'(1) == avail_cnt) ? '0 : (r_pos + CNT_W'(1));
        end
    end

    always_comb begin
        n_state      = r_state;
        n_task_id    = r_task_id;
        n_cpt        = r_cpt;
        n_pos        = r_pos;
        n_k          = r_k;
        n_prod       = r_prod;
        n_mask       = r_mask;
        n_res_status = r_res_status;
        n_out_valid  = r_out_valid && i_out_stall;
        n_out_mask   = r_out_mask;
        n_out_status = r_out_status;
        rank_start   = 1'b0;
        div_start    = 1'b0;
        div_dividend = r_prod;
        div_divisor  = avail_cnt;
        map_raddr    = r_pos[IW-1:0];
        rank_raddr   = map_rdata[IW-1:0];
        case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    n_mask    = '0;
                    n_task_id = i_task_id;
                    if (i_req_type == REQ_LOAD) begin
                        n_res_status = ST_LOADED;
                        n_state      = S_DONE;
                    end else begin
                        rank_start = 1'b1;
                        n_state    = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (rank_stat.done) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                div_dividend = DIVD_W'(avail_cnt);
                div_divisor  = tasks_eff;
                if (skip) begin
                    n_res_status = ST_SKIP;
                    n_state      = S_DONE;
                end else if (cpt_derive) begin
                    div_start = 1'b1;
                    n_state   = S_DIV_CPT;
                end else begin
                    n_cpt   = r_req_cpt;
                    n_state = S_MUL;
                end
            end
            S_DIV_CPT: begin
                if (div_res.done) begin
                    n_cpt   = div_res.quotient[CNT_W-1:0];
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                n_prod  = DIVD_W'(r_task_id) * DIVD_W'(r_cpt) + DIVD_W'(r_start);
                n_state = S_POS_GO;
            end
            S_POS_GO: begin
                div_start = 1'b1;
                n_state   = S_DIV_POS;
            end
            S_DIV_POS: begin
                if (div_res.done) begin
                    n_pos   = rem_pos;
                    n_k     = '0;
                    n_state = S_MAP_RD;
                end
            end
            S_MAP_RD: begin
                n_state = S_RANK;
            end
            S_RANK: begin
                if (id_bad) begin
                    n_res_status = ST_ERROR;
                    n_mask       = '0;
                    n_state      = S_DONE;
                end else begin
                    n_state = S_ACC;
                end
            end
            S_ACC: begin
                n_mask[rank_rdata] = 1'b1;
                if (r_k + CNT_W'(1) == r_cpt) begin
                    n_res_status = ST_MASK;
                    n_state      = S_DONE;
                end else begin
                    n_k       = r_k + CNT_W'(1);
                    n_pos     = pos_next;
                    map_raddr = pos_next[IW-1:0];
                    n_state   = S_RANK;
                end
            end
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid  = 1'b1;
                    n_out_mask   = r_mask;
                    n_out_status = r_res_status;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_task_id    <= n_task_id;
        r_cpt        <= n_cpt;
        r_pos        <= n_pos;
        r_k          <= n_k;
        r_prod       <= n_prod;
        r_mask       <= n_mask;
        r_res_status <= n_res_status;
        r_out_mask   <= n_out_mask;
        r_out_status <= n_out_status;
    end

    assign o_out_valid = r_out_valid;
    assign o_cpu_mask  = 64'(r_out_mask);
    assign o_status    = r_out_status;

endmodule
